>>> design/wslm_pkg.sv
package wslm_pkg;

  localparam int MEASURE_W = 30;
  localparam int COUNT_W = 16;
  localparam int LIMIT_W = 23;
  localparam int STATUS_W = 2;
  localparam int ADDR_W = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [MEASURE_W-1:0] MEASURE_MAX = 30'h3FFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STALLED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER_LIMIT = 2'd2;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_QUIET_BAND = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STALL_AFTER = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_FORCE_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_FORCE_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_FORCE_Z = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_TORQUE_X = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_TORQUE_Y = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SAFETY_TORQUE_Z = 3'd7;

  localparam logic [MEASURE_W-1:0] QUIET_BAND_RESET = '0;
  localparam logic [COUNT_W-1:0] STALL_AFTER_RESET = 16'd100;
  localparam logic [LIMIT_W-1:0] SAFETY_LIMIT_RESET = 23'h7F_FFFF;

  typedef struct packed {
    logic [MEASURE_W-1:0] quiet_band;
    logic [COUNT_W-1:0]   stall_after;
  } stall_cfg_t;

  typedef struct packed {
    logic [MEASURE_W-1:0] change_measure;
    logic [STATUS_W-1:0]  status;
  } result_t;

endpackage

>>> design/wslm_lane.sv
module wslm_lane #(
  parameter int SAMPLE_WIDTH = 24,
  localparam int FULL_W = SAMPLE_WIDTH + 1,
  localparam int MAG_W = (FULL_W > 30) ? 30 : FULL_W,
  localparam int ROOT_W = MAG_W + 1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [SAMPLE_WIDTH-1:0] cur [3],
  input  logic signed [SAMPLE_WIDTH-1:0] prev [3],
  output logic                           done,
  output logic                           ovf,
  output logic [ROOT_W-1:0]              norm
);

  localparam int EXT_W = (FULL_W > 30) ? FULL_W : 31;
  localparam int PROD_W = 2 * MAG_W;
  localparam int SUM_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ROOT_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] SQ_LAST = CNT_W'(3);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SQ   = 2'd1;
  localparam logic [1:0] ST_ROOT = 2'd2;

  logic [1:0]              state;
  logic [CNT_W-1:0]        cnt;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W-1:0]        sum;
  logic [REM_W-1:0]        rem;
  logic [ROOT_W-1:0]       root;

  logic signed [FULL_W-1:0] diff [3];
  logic [FULL_W-1:0]        mag_full [3];
  logic [EXT_W-1:0]         mag_ext [3];
  logic [MAG_W-1:0]         mag [3];
  logic [2:0]               ovf_ax;
  logic [MAG_W-1:0]         sel;
  logic [REM_W-1:0]         rem_sh;
  logic [REM_W-1:0]         trial;
  logic                     geq;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = FULL_W'(cur[i]) - FULL_W'(prev[i]);
      mag_full[i] = diff[i][FULL_W-1] ? FULL_W'(-diff[i]) : FULL_W'(diff[i]);
      mag_ext[i] = EXT_W'(mag_full[i]);
      ovf_ax[i] = |(mag_ext[i] >> 30);
      mag[i] = mag_ext[i][MAG_W-1:0];
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    sel = mag[0];
      2'd1:    sel = mag[1];
      2'd2:    sel = mag[2];
      default: sel = '0;
    endcase
  end

  // one result bit per step, two radicand bits shifted in
  assign rem_sh = {rem[REM_W-3:0], sum[SUM_W-1 -: 2]};
  assign trial = {root, 2'b01};
  assign geq = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_SQ;
            cnt <= '0;
          end
        end
        ST_SQ: begin
          if (cnt == SQ_LAST) begin
            state <= ST_ROOT;
            cnt <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_ROOT: begin
          if (cnt == LAST_STEP) begin
            state <= ST_IDLE;
            done <= 1'b1;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      sum <= '0;
      rem <= '0;
      root <= '0;
    end else if (state == ST_SQ) begin
      // product registered before it is accumulated
      prod <= PROD_W'(sel) * PROD_W'(sel);
      if (cnt != '0) begin
        sum <= sum + SUM_W'(prod);
      end
    end else if (state == ST_ROOT) begin
      sum <= sum << 2;
      rem <= geq ? (rem_sh - trial) : rem_sh;
      root <= {root[ROOT_W-2:0], geq};
      if (cnt == LAST_STEP) begin
        ovf <= |ovf_ax;
      end
    end
  end

  assign norm = root;

endmodule

>>> design/wslm_merge.sv
module wslm_merge #(
  parameter int ROOT_W = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ROOT_W-1:0]           fnorm,
  input  logic [ROOT_W-1:0]           tnorm,
  input  logic                        fovf,
  input  logic                        tovf,
  input  logic                        over_limit,
  input  wslm_pkg::stall_cfg_t        cfg,
  input  logic                        take,
  output logic                        fire,
  output wslm_pkg::result_t           res
);
  import wslm_pkg::*;

  localparam int WIDE_W = (ROOT_W + 4 > MEASURE_W + 1) ? ROOT_W + 4 : MEASURE_W + 1;

  logic                 pend;
  logic [MEASURE_W-1:0] measure;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   count_next;
  logic [WIDE_W-1:0]    wide;
  logic                 changed;
  logic                 stalled;

  // f + 10*t as f + 8t + 2t
  assign wide = WIDE_W'(fnorm) + (WIDE_W'(tnorm) << 3) + (WIDE_W'(tnorm) << 1);

  assign changed = (measure > cfg.quiet_band);
  assign fire = pend & take;

  always_comb begin
    if (changed) begin
      count_next = '0;
      stalled = 1'b0;
    end else begin
      count_next = (count == COUNT_MAX) ? count : count + 1'b1;
      stalled = (count_next >= cfg.stall_after);
    end
  end

  always_comb begin
    res.change_measure = measure;
    if (stalled) begin
      res.status = STATUS_STALLED;
    end else if (over_limit) begin
      res.status = STATUS_OVER_LIMIT;
    end else begin
      res.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      count <= '0;
    end else begin
      if (start) begin
        pend <= 1'b1;
      end else if (fire) begin
        pend <= 1'b0;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      if (fovf || tovf || wide > WIDE_W'(MEASURE_MAX)) begin
        measure <= MEASURE_MAX;
      end else begin
        measure <= wide[MEASURE_W-1:0];
      end
    end
  end

endmodule

>>> design/wrench_stall_and_limit_monitor.sv
// channel | dir | handshake            | payload
// s_*     | in  | s_tvalid / s_tready  | s_tdata: force_x..torque_z, SAMPLE_WIDTH bits each
// m_*     | out | m_tvalid / m_tready  | m_tdata: status, change_measure
// apb     | in  | psel/penable/pready  | 8 registers at 4*i, 32-bit data
//
// One sample at a time; the time from accept to the next accept is set by the bit-serial
// square root in each lane (one root bit per cycle, ROOT_W = SAMPLE_WIDTH + 2 up to 29 bits);
// the result then reaches m_tdata through the merge stage.
// s_tready drops from accept until the result is loaded into the output register.
// A result may wait in m_tdata while the next sample is already accepted.
// Reset is synchronous and clears control state, counter, stored sample and registers.
module wrench_stall_and_limit_monitor #(
  parameter int SAMPLE_WIDTH = 24,
  localparam int IN_BITS = 6 * SAMPLE_WIDTH,
  localparam int IN_W = ((IN_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [IN_W-1:0]               s_tdata,  // force_x, force_y, force_z, torque_x, torque_y, torque_z
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [31:0]                   m_tdata,  // status[1:0], change_measure[31:2]
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wslm_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import wslm_pkg::*;

  localparam int FULL_W = SAMPLE_WIDTH + 1;
  localparam int MAG_W = (FULL_W > 30) ? 30 : FULL_W;
  localparam int ROOT_W = MAG_W + 1;
  localparam int CMP_W = (SAMPLE_WIDTH > LIMIT_W) ? SAMPLE_WIDTH : LIMIT_W;

  logic [MEASURE_W-1:0]           quiet_band;
  logic [COUNT_W-1:0]             stall_after;
  logic [LIMIT_W-1:0]             safety [6];
  logic signed [SAMPLE_WIDTH-1:0] cur [6];
  logic signed [SAMPLE_WIDTH-1:0] prev [6];
  logic signed [SAMPLE_WIDTH-1:0] in_axis [6];
  logic [SAMPLE_WIDTH-1:0]        in_mag [6];
  logic [5:0]                     in_over;
  logic                           over_limit;
  logic                           busy;
  logic                           start;
  logic                           s_fire;
  logic                           cfg_wr;
  logic [REG_IDX_W-1:0]           reg_idx;

  logic               fdone, tdone, fovf, tovf;
  logic [ROOT_W-1:0]  fnorm, tnorm;
  logic               take, fire;
  stall_cfg_t         cfg;
  result_t            res;

  assign s_tready = ~busy;
  assign s_fire = s_tvalid & s_tready;
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign reg_idx = paddr[ADDR_W-1:2];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_axis[i] = s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH];
      // most negative value maps to 2^(W-1), still fits unsigned
      in_mag[i] = in_axis[i][SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-in_axis[i])
                                             : SAMPLE_WIDTH'(in_axis[i]);
      in_over[i] = (CMP_W'(in_mag[i]) > CMP_W'(safety[i]));
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      quiet_band <= QUIET_BAND_RESET;
      stall_after <= STALL_AFTER_RESET;
      for (int i = 0; i < 6; i++) begin
        safety[i] <= SAFETY_LIMIT_RESET;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_QUIET_BAND:      quiet_band <= pwdata[MEASURE_W-1:0];
        REG_STALL_AFTER:     stall_after <= pwdata[COUNT_W-1:0];
        REG_SAFETY_FORCE_X:  safety[0] <= pwdata[LIMIT_W-1:0];
        REG_SAFETY_FORCE_Y:  safety[1] <= pwdata[LIMIT_W-1:0];
        REG_SAFETY_FORCE_Z:  safety[2] <= pwdata[LIMIT_W-1:0];
        REG_SAFETY_TORQUE_X: safety[3] <= pwdata[LIMIT_W-1:0];
        REG_SAFETY_TORQUE_Y: safety[4] <= pwdata[LIMIT_W-1:0];
        REG_SAFETY_TORQUE_Z: safety[5] <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_QUIET_BAND:      prdata = 32'(quiet_band);
      REG_STALL_AFTER:     prdata = 32'(stall_after);
      REG_SAFETY_FORCE_X:  prdata = 32'(safety[0]);
      REG_SAFETY_FORCE_Y:  prdata = 32'(safety[1]);
      REG_SAFETY_FORCE_Z:  prdata = 32'(safety[2]);
      REG_SAFETY_TORQUE_X: prdata = 32'(safety[3]);
      REG_SAFETY_TORQUE_Y: prdata = 32'(safety[4]);
      REG_SAFETY_TORQUE_Z: prdata = 32'(safety[5]);
      default:             prdata = '0;
    endcase
  end

  // sample capture and control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      start <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        prev[i] <= '0;
      end
    end else begin
      start <= s_fire;
      if (s_fire) begin
        busy <= 1'b1;
      end else if (fire) begin
        busy <= 1'b0;
        for (int i = 0; i < 6; i++) begin
          prev[i] <= cur[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      for (int i = 0; i < 6; i++) begin
        cur[i] <= in_axis[i];
      end
      over_limit <= |in_over;
    end
  end

  wslm_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_force_lane (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cur  (cur[0:2]),
    .prev (prev[0:2]),
    .done (fdone),
    .ovf  (fovf),
    .norm (fnorm)
  );

  wslm_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_torque_lane (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .cur  (cur[3:5]),
    .prev (prev[3:5]),
    .done (tdone),
    .ovf  (tovf),
    .norm (tnorm)
  );

  assign cfg.quiet_band = quiet_band;
  assign cfg.stall_after = stall_after;
  assign take = ~m_tvalid | m_tready;

  wslm_merge #(.ROOT_W(ROOT_W)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (fdone),
    .fnorm     (fnorm),
    .tnorm     (tnorm),
    .fovf      (fovf),
    .tovf      (tovf),
    .over_limit(over_limit),
    .cfg       (cfg),
    .take      (take),
    .fire      (fire),
    .res       (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {res.change_measure, res.status};
    end
  end

  a_lanes_in_step: assert property (@(posedge clk) disable iff (rst)
    fdone == tdone) else $error("force and torque lanes out of step");

  a_start_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> start && busy) else $error("accepted sample did not start lanes");

  a_fire_only_busy: assert property (@(posedge clk) disable iff (rst)
    fire |-> busy && !start) else $error("result issued with no sample in flight");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == STATUS_OK || m_tdata[1:0] == STATUS_STALLED ||
                  m_tdata[1:0] == STATUS_OVER_LIMIT))
    else $error("undefined status code");

endmodule

>>> test/wrench_stall_and_limit_monitor_tb.sv
`timescale 1ns / 1ps

module wrench_stall_and_limit_monitor_tb;
  import wslm_pkg::*;

  localparam int SAMPLE_W = 24;
  localparam int IN_W = 6 * SAMPLE_W;
  localparam int TORQUE_WEIGHT = 10;
  localparam int AXIS_MAX = 8388607;
  localparam int AXIS_MIN = -8388608;
  localparam int PHASE_ITEMS = 275;

  class wrench_status_model;
    logic [MEASURE_W-1:0] quiet_band;
    logic [COUNT_W-1:0]   stall_after;
    logic [LIMIT_W-1:0]   axis_limit [6];
    longint               last_sample [6];
    logic [COUNT_W-1:0]   unchanged_run;
    result_t              expected_reports [$];
    int                   mismatch_count;

    function new();
      quiet_band = QUIET_BAND_RESET;
      stall_after = STALL_AFTER_RESET;
      foreach (axis_limit[i]) begin
        axis_limit[i] = SAFETY_LIMIT_RESET;
        last_sample[i] = 0;
      end
      unchanged_run = '0;
      mismatch_count = 0;
    endfunction

    static function longint unsigned magnitude(longint v);
      return (v < 0) ? -v : v;
    endfunction

    // builds the root one bit at a time from the top
    static function longint unsigned floor_root(longint unsigned x);
      longint unsigned root, trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function void write_reg(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
      case (idx)
        REG_QUIET_BAND: quiet_band = value[MEASURE_W-1:0];
        REG_STALL_AFTER: stall_after = value[COUNT_W-1:0];
        default: axis_limit[idx - REG_SAFETY_FORCE_X] = value[LIMIT_W-1:0];
      endcase
    endfunction

    function void accept_sample(logic [IN_W-1:0] word);
      longint                  axis [6];
      longint unsigned         sq [2];
      longint unsigned         diff, measure;
      logic signed [SAMPLE_W-1:0] field;
      bit                      saturate;
      result_t                 rep;
      saturate = 1'b0;
      sq[0] = 0;
      sq[1] = 0;
      for (int i = 0; i < 6; i++) begin
        field = word[i*SAMPLE_W +: SAMPLE_W];
        axis[i] = field;
        diff = magnitude(axis[i] - last_sample[i]);
        if (diff >= (64'd1 << MEASURE_W)) saturate = 1'b1;
        sq[i / 3] += diff * diff;
      end
      measure = floor_root(sq[0]) + TORQUE_WEIGHT * floor_root(sq[1]);
      if (saturate || measure > MEASURE_MAX) measure = MEASURE_MAX;

      rep.status = STATUS_OK;
      if (measure > quiet_band) begin
        unchanged_run = '0;
      end else begin
        if (unchanged_run != COUNT_MAX) unchanged_run++;
        if (unchanged_run >= stall_after) rep.status = STATUS_STALLED;
      end
      // stalled wins over the limit check
      if (rep.status == STATUS_OK) begin
        for (int i = 0; i < 6; i++)
          if (magnitude(axis[i]) > axis_limit[i]) rep.status = STATUS_OVER_LIMIT;
      end
      rep.change_measure = measure[MEASURE_W-1:0];
      last_sample = axis;
      expected_reports.push_back(rep);
    endfunction

    function void check_report(logic [31:0] word);
      result_t got, want;
      got = result_t'(word);
      if (expected_reports.size() == 0) begin
        $display("%0t: unexpected result transfer: status %0d, change %0d",
                 $time, got.status, got.change_measure);
        mismatch_count++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        mismatch_count++;
      end
      if (got.change_measure !== want.change_measure) begin
        $display("%0t: change_measure mismatch: expected %0d, actual %0d",
                 $time, want.change_measure, got.change_measure);
        mismatch_count++;
      end
    endfunction

    function int pending_count();
      return expected_reports.size();
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            s_tvalid = 1'b0;
  logic            s_tready;
  logic [IN_W-1:0] s_tdata = '0;
  logic            m_tvalid;
  logic            m_tready = 1'b0;
  logic [31:0]     m_tdata;
  logic            psel = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite = 1'b0;
  logic [4:0]      paddr = '0;
  logic [31:0]     pwdata = '0;
  logic [31:0]     prdata;
  logic            pready;

  wrench_status_model status_model = new();
  logic [IN_W-1:0]    sample_queue [$];
  int                 walk [6];
  int                 lim_cfg [6];
  int                 rx_left = 0;
  int                 rx_mode = 0;

  wrench_stall_and_limit_monitor #(.SAMPLE_WIDTH(SAMPLE_W)) DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // transfers seen at the rising edge feed the model
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) status_model.check_report(m_tdata);
      if (s_tvalid && s_tready) status_model.accept_sample(s_tdata);
      if (psel && penable && pwrite && pready) status_model.write_reg(paddr[4:2], pwdata);
    end
  end

  // receiver: open stretches, closed stretches and coin-flip stretches
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = (rx_mode == 0) ? $urandom_range(20, 200) : $urandom_range(1, 40);
    end
    rx_left--;
    m_tready <= (rx_mode == 0) || (rx_mode == 2 && $urandom_range(0, 1) == 1);
  end

  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int clamp_axis(int v);
    if (v > AXIS_MAX) return AXIS_MAX;
    if (v < AXIS_MIN) return AXIS_MIN;
    return v;
  endfunction

  task automatic push_walk();
    logic [IN_W-1:0] word;
    for (int i = 0; i < 6; i++) word[i*SAMPLE_W +: SAMPLE_W] = walk[i][SAMPLE_W-1:0];
    sample_queue.push_back(word);
  endtask

  task automatic queue_axes(int a0, int a1, int a2, int a3, int a4, int a5);
    walk = '{a0, a1, a2, a3, a4, a5};
    push_walk();
  endtask

  // segments of held, jittered, near-limit, random and extreme samples
  task automatic queue_random_phase(int count);
    int kind, seg_len, amp, v;
    logic signed [SAMPLE_W-1:0] r24;
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      seg_len = (kind < 3) ? $urandom_range(1, 30) : $urandom_range(1, 12);
      case ($urandom_range(0, 4))
        0: amp = 1;
        1: amp = 3;
        2: amp = 40;
        3: amp = 1500;
        default: amp = 60000;
      endcase
      for (int k = 0; k < seg_len && count > 0; k++) begin
        for (int i = 0; i < 6; i++) begin
          case (kind) inside
            [0:2]: ;
            [3:5]: walk[i] = clamp_axis(walk[i] + int'($urandom_range(0, 2 * amp)) - amp);
            6: begin
              v = lim_cfg[i] + $urandom_range(0, 1);
              walk[i] = clamp_axis($urandom_range(0, 1) ? -v : v);
            end
            [7:8]: begin
              r24 = SAMPLE_W'($urandom);
              walk[i] = r24;
            end
            default: begin
              case ($urandom_range(0, 3))
                0: walk[i] = AXIS_MAX;
                1: walk[i] = AXIS_MIN;
                2: walk[i] = 0;
                default: walk[i] = -1;
              endcase
            end
          endcase
        end
        push_walk();
        count--;
      end
    end
  endtask

  task automatic send_samples();
    int burst_left, gap;
    burst_left = 0;
    while (sample_queue.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap != 0) begin
          s_tvalid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      s_tdata = sample_queue.pop_front();
      s_tvalid = 1'b1;
      @(posedge clk);
      while (!s_tready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    s_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    while (status_model.pending_count() != 0) @(negedge clk);
  endtask

  // upper pwdata bits are noise; the block must drop them
  task automatic apb_write(logic [REG_IDX_W-1:0] idx, logic [31:0] value, int width);
    logic [31:0] keep;
    keep = (32'd1 << width) - 1;
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = ($urandom & ~keep) | (value & keep);
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_config(int unsigned noise, int unsigned thr);
    apb_write(REG_QUIET_BAND, noise, MEASURE_W);
    apb_write(REG_STALL_AFTER, thr, COUNT_W);
    for (int i = 0; i < 6; i++)
      apb_write(REG_IDX_W'(REG_SAFETY_FORCE_X + i), lim_cfg[i], LIMIT_W);
  endtask

  initial begin : stimulus
    repeat (10) @(negedge clk);
    rst = 1'b0;
    foreach (lim_cfg[i]) lim_cfg[i] = AXIS_MAX;

    // reset settings: full-scale samples, most negative value over the limit
    queue_axes(0, 0, 0, 0, 0, 0);
    queue_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MAX);
    queue_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN, AXIS_MIN);
    queue_axes(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN);
    queue_axes(AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN, AXIS_MAX, AXIS_MIN);
    send_samples();
    wait_idle();

    // limits at the sample magnitude; stall after two unchanged samples
    foreach (lim_cfg[i]) lim_cfg[i] = 1000;
    apply_config(0, 2);
    repeat (3) queue_axes(1000, -1000, 1000, -1000, 1000, -1000);
    queue_axes(1001, -1000, 1000, -1000, 1000, -1000);
    queue_axes(1000, -1000, 1000, -1000, 1000, -1001);
    // held over-limit sample: over limit, then stalled
    repeat (2) queue_axes(1000, -1000, 1000, -1000, 1000, -1001);
    send_samples();
    wait_idle();

    // zero threshold; change exactly at the noise level is still unchanged
    apply_config(10, 0);
    queue_axes(1000, -1000, 1000, -1000, 1000, -1000);
    queue_axes(1011, -1000, 1000, -1000, 1000, -1000);
    queue_axes(1000, -1000, 1000, -1000, 1000, -1000);
    queue_axes(1000, -1000, 1000, -1000, 1000, -1000);
    send_samples();
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          foreach (lim_cfg[i]) lim_cfg[i] = AXIS_MAX;
          apply_config(0, 1);
        end
        1: begin
          foreach (lim_cfg[i]) lim_cfg[i] = $urandom_range(0, AXIS_MAX);
          apply_config(2000, 3);
        end
        2: begin
          foreach (lim_cfg[i]) lim_cfg[i] = 0;
          apply_config(32'h3FFF_FFFF, 65535);
        end
        3: begin
          foreach (lim_cfg[i]) lim_cfg[i] = $urandom_range(0, 2000000);
          apply_config(500, 0);
        end
        4: begin
          foreach (lim_cfg[i]) lim_cfg[i] = $urandom_range(0, AXIS_MAX);
          apply_config(100000, 5);
        end
        default: begin
          foreach (lim_cfg[i]) lim_cfg[i] = $urandom_range(0, AXIS_MAX);
          apply_config($urandom_range(0, 32'h3FFF_FFFF), $urandom_range(0, 20));
        end
      endcase
      queue_random_phase(PHASE_ITEMS);
      send_samples();
      wait_idle();
    end

    repeat (60) @(negedge clk);
    if (status_model.mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
